FILE: src/ffc_pkg.sv
// Shared types and constants of the first-order filter cascade.
package ffc_pkg;

  localparam int STATE_BITS = 24;
  localparam int MAX_STAGES = 8;
  localparam int KINDS_RESET = 4;

  localparam int GAIN_RESET [MAX_STAGES] = '{130304, 127402, 74163, 0, 0, 0, 0, 0};
  localparam int FBK_RESET  [MAX_STAGES] = '{-129537, -123731, 17255, 0, 0, 0, 0, 0};

  // Input command codes.
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // One sample travelling between neighbouring sections.
  typedef struct packed {
    logic                          vld;
    logic signed [STATE_BITS-1:0] smp;
    logic                          clip;
  } link_t;

  typedef enum logic [1:0] {
    CELL_IDLE,
    CELL_FWD,
    CELL_FBK,
    CELL_SUM
  } cell_state_t;

endpackage

FILE: src/ffc_cell.sv
// One first-order IIR section with its own state and a single time-shared multiplier.
module ffc_cell #(
  parameter int COEF_BITS = 18
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clr,
  input  logic                        lowpass,
  input  logic signed [COEF_BITS-1:0] gain,
  input  logic signed [COEF_BITS-1:0] fbk,
  input  ffc_pkg::link_t              link_i,
  output ffc_pkg::link_t              link_o
);

  localparam int SW  = ffc_pkg::STATE_BITS;
  localparam int DW  = SW + 1;
  localparam int PW  = DW + COEF_BITS;
  localparam int ACW = PW + 1;
  localparam logic signed [ACW-1:0] HALF = ACW'(1) << (COEF_BITS - 2);
  localparam logic signed [ACW-1:0] SMAX = (ACW'(1) << (SW - 1)) - ACW'(1);
  localparam logic signed [ACW-1:0] SMIN = -SMAX - ACW'(1);

  ffc_pkg::cell_state_t state_r, state_nxt;

  logic signed [SW-1:0]        x_r;
  logic signed [SW-1:0]        pin_r;
  logic signed [SW-1:0]        pout_r;
  logic signed [DW-1:0]        diff_r;
  logic signed [PW-1:0]        p_r;
  logic signed [PW-1:0]        q_r;
  logic                        clip_r;
  ffc_pkg::link_t              link_r;

  logic                        sel_fwd;
  logic signed [DW-1:0]        mul_a;
  logic signed [COEF_BITS-1:0] mul_b;
  logic signed [PW-1:0]        prod;
  logic signed [DW-1:0]        x_ext;
  logic signed [DW-1:0]        pin_ext;
  logic signed [ACW-1:0]       acc;
  logic signed [ACW-1:0]       rnd;
  logic signed [SW-1:0]        y;
  logic                        sat;

  always_comb begin
    state_nxt = state_r;
    sel_fwd   = 1'b0;
    case (state_r)
      ffc_pkg::CELL_IDLE: begin
        if (link_i.vld) begin
          state_nxt = ffc_pkg::CELL_FWD;
        end
      end
      ffc_pkg::CELL_FWD: begin
        sel_fwd   = 1'b1;
        state_nxt = ffc_pkg::CELL_FBK;
      end
      ffc_pkg::CELL_FBK: begin
        state_nxt = ffc_pkg::CELL_SUM;
      end
      ffc_pkg::CELL_SUM: begin
        state_nxt = ffc_pkg::CELL_IDLE;
      end
      default: begin
        state_nxt = ffc_pkg::CELL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffc_pkg::CELL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The feed-forward pair b0*x + b1*x_prev is folded into b0*(x +/- x_prev).
  assign x_ext   = DW'($signed(link_i.smp));
  assign pin_ext = DW'(pin_r);
  assign mul_a   = sel_fwd ? diff_r : DW'(pout_r);
  assign mul_b   = sel_fwd ? gain : fbk;
  assign prod    = PW'(mul_a) * PW'(mul_b);

  assign acc = ACW'(p_r) - ACW'(q_r);
  assign rnd = (acc + HALF) >>> (COEF_BITS - 1);

  always_comb begin
    sat = 1'b0;
    y   = rnd[SW-1:0];
    if (rnd > SMAX) begin
      sat = 1'b1;
      y   = SMAX[SW-1:0];
    end else if (rnd < SMIN) begin
      sat = 1'b1;
      y   = SMIN[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ffc_pkg::CELL_IDLE && link_i.vld) begin
      x_r    <= link_i.smp;
      clip_r <= link_i.clip;
      diff_r <= lowpass ? (x_ext + pin_ext) : (x_ext - pin_ext);
    end
    if (state_r == ffc_pkg::CELL_FWD) begin
      p_r <= prod;
    end
    if (state_r == ffc_pkg::CELL_FBK) begin
      q_r <= prod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r      <= '0;
      pout_r     <= '0;
      link_r.vld <= 1'b0;
    end else begin
      link_r.vld <= (state_r == ffc_pkg::CELL_SUM);
      if (state_r == ffc_pkg::CELL_SUM) begin
        link_r.smp  <= y;
        link_r.clip <= clip_r | sat;
      end
      if (clr) begin
        pin_r  <= '0;
        pout_r <= '0;
      end else if (state_r == ffc_pkg::CELL_SUM) begin
        pin_r  <= x_r;
        pout_r <= y;
      end
    end
  end

  assign link_o = link_r;

  a_in_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    link_i.vld |-> state_r == ffc_pkg::CELL_IDLE)
    else $error("sample arrived while the section was busy");

  a_clr_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clr |-> state_r == ffc_pkg::CELL_IDLE && !link_i.vld)
    else $error("clear arrived while the section was busy");

  a_state_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ffc_pkg::CELL_SUM |=> link_o.vld && pout_r == link_o.smp)
    else $error("stored output differs from the sample passed on");

endmodule

FILE: src/ffc_out.sv
// Final rounding to the output width, output register and one-entry hold stage.
module ffc_out #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ffc_pkg::link_t         link_i,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [SAMPLE_BITS-1:0] out_sample,
  output logic                   out_clip,
  output logic                   hold_full
);

  localparam int SW = ffc_pkg::STATE_BITS;
  localparam int NW = SW + 1;
  localparam int SH = SW - SAMPLE_BITS;
  localparam logic signed [NW-1:0] HALF = (SH == 0) ? NW'(0) : (NW'(1) << ((SH == 0) ? 0 : SH - 1));
  localparam logic signed [NW-1:0] OMAX = (NW'(1) << (SAMPLE_BITS - 1)) - NW'(1);
  localparam logic signed [NW-1:0] OMIN = -OMAX - NW'(1);

  logic signed [NW-1:0]   rnd;
  logic [SAMPLE_BITS-1:0] narrow;
  logic                   narrow_clip;

  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;
  logic                   out_clip_r;
  logic                   hold_valid_r;
  logic [SAMPLE_BITS-1:0] hold_sample_r;
  logic                   hold_clip_r;
  logic                   take;

  assign rnd = (NW'($signed(link_i.smp)) + HALF) >>> SH;

  always_comb begin
    narrow      = rnd[SAMPLE_BITS-1:0];
    narrow_clip = link_i.clip;
    if (rnd > OMAX) begin
      narrow      = OMAX[SAMPLE_BITS-1:0];
      narrow_clip = 1'b1;
    end else if (rnd < OMIN) begin
      narrow      = OMIN[SAMPLE_BITS-1:0];
      narrow_clip = 1'b1;
    end
  end

  assign take = out_valid_r & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      if (link_i.vld) begin
        if (!out_valid_r || take) begin
          out_valid_r  <= 1'b1;
          out_sample_r <= narrow;
          out_clip_r   <= narrow_clip;
        end else begin
          hold_valid_r  <= 1'b1;
          hold_sample_r <= narrow;
          hold_clip_r   <= narrow_clip;
        end
      end else if (take) begin
        if (hold_valid_r) begin
          out_sample_r <= hold_sample_r;
          out_clip_r   <= hold_clip_r;
          hold_valid_r <= 1'b0;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_clip   = out_clip_r;
  assign hold_full  = hold_valid_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    link_i.vld |-> !hold_valid_r)
    else $error("new result while the hold stage is occupied");

  a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r |-> out_valid_r)
    else $error("hold stage full with an empty output register");

  a_hold_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(hold_valid_r) |-> $past(out_valid_r && !out_ready && link_i.vld))
    else $error("hold stage filled without a stalled output");

endmodule

FILE: src/first_order_filter_cascade_unit.sv
// Top level of the first-order IIR filter cascade: configuration, input control and cell chain.
//
//  channel  direction  tdata                          tuser
//  in_      slave      sample_in, zero-padded         command
//  out_     master     sample_out, zero-padded        clipped
//  cfg_     write      cfg_data: coefficient / kinds  -
//
// Each section steps through latch, b0 product, a1 product and sum, using its one multiplier
// twice. A sample passes the sections one after another into the output register; the next
// sample is taken once its result has left the last section, if the hold stage is not full.
// A clear transaction gives no result.
// Reset loads the default coefficients and zeroes all section state.
// While a result waits at the output, one further sample may be filtered into a hold stage.
module first_order_filter_cascade_unit #(
  parameter int STAGES      = 3,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 18
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  in_tdata,   // [SAMPLE_BITS-1:0] sample_in
  input  logic                              in_tuser,   // [0] command
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]  out_tdata,  // [SAMPLE_BITS-1:0] sample_out
  output logic                              out_tuser,  // [0] clipped
  input  logic                              cfg_we,
  input  logic [$clog2(2*STAGES+1)-1:0]     cfg_addr,
  input  logic [COEF_BITS-1:0]              cfg_data
);

  localparam int SW       = ffc_pkg::STATE_BITS;
  localparam int TW       = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int AW       = $clog2(2 * STAGES + 1);
  localparam int SH       = SW - SAMPLE_BITS;
  localparam int REG_KINDS = 2 * STAGES;

  logic signed [COEF_BITS-1:0] gain_r [STAGES];
  logic signed [COEF_BITS-1:0] fbk_r  [STAGES];
  logic [STAGES-1:0]           kinds_r;
  logic                        inflight_r;

  logic                        accept;
  logic                        clr_cmd;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                        hold_full;
  logic [SAMPLE_BITS-1:0]      out_sample;
  ffc_pkg::link_t              links [STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STAGES; s++) begin
        gain_r[s] <= COEF_BITS'(ffc_pkg::GAIN_RESET[s]);
        fbk_r[s]  <= COEF_BITS'(ffc_pkg::FBK_RESET[s]);
      end
      kinds_r <= STAGES'(ffc_pkg::KINDS_RESET);
    end else if (cfg_we) begin
      for (int s = 0; s < STAGES; s++) begin
        if (cfg_addr == AW'(2 * s)) begin
          gain_r[s] <= cfg_data;
        end
        if (cfg_addr == AW'(2 * s + 1)) begin
          fbk_r[s] <= cfg_data;
        end
      end
      if (cfg_addr == AW'(REG_KINDS)) begin
        kinds_r <= cfg_data[STAGES-1:0];
      end
    end
  end

  assign in_tready = !inflight_r && !hold_full;
  assign accept    = in_tvalid && in_tready;
  assign clr_cmd   = accept && (in_tuser == ffc_pkg::CMD_CLEAR);
  assign in_sample = in_tdata[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 1'b0;
    end else if (links[0].vld) begin
      inflight_r <= 1'b1;
    end else if (links[STAGES].vld) begin
      inflight_r <= 1'b0;
    end
  end

  always_comb begin
    links[0].vld  = accept && (in_tuser == ffc_pkg::CMD_FILTER);
    links[0].smp  = SW'(in_sample) <<< SH;
    links[0].clip = 1'b0;
  end

  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    ffc_cell #(
      .COEF_BITS(COEF_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .clr     (clr_cmd),
      .lowpass (kinds_r[g]),
      .gain    (gain_r[g]),
      .fbk     (fbk_r[g]),
      .link_i  (links[g]),
      .link_o  (links[g+1])
    );
  end

  ffc_out #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .link_i     (links[STAGES]),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_sample (out_sample),
    .out_clip   (out_tuser),
    .hold_full  (hold_full)
  );

  assign out_tdata = TW'(out_sample);

  a_launch_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
    links[0].vld |=> inflight_r)
    else $error("sample launched without marking the chain busy");

  a_clear_when_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clr_cmd |-> !inflight_r)
    else $error("clear accepted while a sample was in the chain");

  a_result_expected: assert property (@(posedge clk) disable iff (!rst_n)
    links[STAGES].vld |-> inflight_r)
    else $error("result left the chain with no sample in flight");

endmodule

FILE: test/first_order_filter_cascade_unit_tb.sv
// Testbench of the first-order filter cascade: random and directed samples checked against a predictor.
module first_order_filter_cascade_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SECTIONS   = 3;
  localparam int SMP_BITS   = 16;
  localparam int COEF_W     = 18;
  localparam int SETTLE_CYC = 40;
  localparam longint RUN_LIMIT_NS = 64'd20_000_000;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_A_GAIN = 3'd0;
  localparam logic [2:0] REG_A_FBK  = 3'd1;
  localparam logic [2:0] REG_B_GAIN = 3'd2;
  localparam logic [2:0] REG_B_FBK  = 3'd3;
  localparam logic [2:0] REG_C_GAIN = 3'd4;
  localparam logic [2:0] REG_C_FBK  = 3'd5;
  localparam logic [2:0] REG_KINDS  = 3'd6;
  localparam logic [2:0] REG_SPARE  = 3'd7;

  localparam logic signed [COEF_W-1:0] COEF_MAX = 18'sh1FFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 18'sh20000;

  typedef struct {
    logic signed [SMP_BITS-1:0] smp;
    logic                       clip;
  } filtered_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [17:0] cfg_data;

  // Predictor copy of the coefficients and section state.
  logic signed [COEF_W-1:0]     sec_gain [SECTIONS];
  logic signed [COEF_W-1:0]     sec_fbk  [SECTIONS];
  logic [SECTIONS-1:0]          sec_lowpass;
  logic signed [ffc_pkg::STATE_BITS-1:0] sec_prev_in  [SECTIONS];
  logic signed [ffc_pkg::STATE_BITS-1:0] sec_prev_out [SECTIONS];

  filtered_t pending_results[$];
  int        mismatches;
  bit        steady;

  first_order_filter_cascade_unit #(
    .STAGES      (SECTIONS),
    .SAMPLE_BITS (SMP_BITS),
    .COEF_BITS   (COEF_W)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic signed [SMP_BITS-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
    if (r < 35) return 16'($signed($urandom_range(0, 512)) - 256);
    return 16'($urandom);
  endfunction

  function automatic longint clamp(longint v, int bits, inout logic hit);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Runs one sample through all sections, updating the stored state.
  function automatic filtered_t filter_sample(logic signed [SMP_BITS-1:0] smp);
    filtered_t res;
    longint    x;
    longint    y;
    longint    b0;
    longint    b1;
    longint    acc;
    logic      hit;
    hit = 1'b0;
    x = longint'(smp) * (64'sd1 <<< (ffc_pkg::STATE_BITS - SMP_BITS));
    for (int s = 0; s < SECTIONS; s++) begin
      b0 = longint'(sec_gain[s]);
      b1 = sec_lowpass[s] ? b0 : -b0;
      acc = b0 * x + b1 * longint'(sec_prev_in[s]) - longint'(sec_fbk[s]) * longint'(sec_prev_out[s]);
      y = clamp((acc + (64'sd1 <<< (COEF_W - 2))) >>> (COEF_W - 1), ffc_pkg::STATE_BITS, hit);
      sec_prev_in[s]  = x[ffc_pkg::STATE_BITS-1:0];
      sec_prev_out[s] = y[ffc_pkg::STATE_BITS-1:0];
      x = y;
    end
    y = clamp((x + (64'sd1 <<< (ffc_pkg::STATE_BITS - SMP_BITS - 1)))
              >>> (ffc_pkg::STATE_BITS - SMP_BITS), SMP_BITS, hit);
    res.smp  = y[SMP_BITS-1:0];
    res.clip = hit;
    return res;
  endfunction

  task automatic send_item(logic cmd, logic [SMP_BITS-1:0] smp);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = smp;
    do @(posedge clk); while (!in_tready);
    if (cmd == ffc_pkg::CMD_CLEAR) begin
      for (int s = 0; s < SECTIONS; s++) begin
        sec_prev_in[s]  = '0;
        sec_prev_out[s] = '0;
      end
    end else begin
      pending_results.push_back(filter_sample(smp));
    end
  endtask

  task automatic random_items(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 4) send_item(ffc_pkg::CMD_CLEAR, 16'($urandom));
      else send_item(ffc_pkg::CMD_FILTER, pick_sample());
    end
  endtask

  // Stops the input side and waits until the block has nothing left in flight.
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [COEF_W-1:0] value);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_addr = idx;
    cfg_data = value;
    @(posedge clk);
    if (idx < REG_KINDS) begin
      if (idx[0]) sec_fbk[idx >> 1] = value;
      else sec_gain[idx >> 1] = value;
    end else if (idx == REG_KINDS) begin
      sec_lowpass = value[SECTIONS-1:0];
    end
  endtask

  task automatic load_settings(logic [COEF_W-1:0] gain [SECTIONS],
                               logic [COEF_W-1:0] fbk [SECTIONS], logic [COEF_W-1:0] kinds);
    for (int s = 0; s < SECTIONS; s++) begin
      write_reg(REG_A_GAIN + 3'(2 * s), gain[s]);
      write_reg(REG_A_FBK + 3'(2 * s), fbk[s]);
    end
    write_reg(REG_KINDS, kinds);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic test_reset_defaults();
    logic signed [SMP_BITS-1:0] steps [8];
    steps = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0001,
              16'shFFFF, 16'sh4000};
    foreach (steps[i]) send_item(ffc_pkg::CMD_FILTER, steps[i]);
    // The sample field of a clear is ignored, so give it a busy pattern.
    send_item(ffc_pkg::CMD_CLEAR, 16'hA5A5);
    send_item(ffc_pkg::CMD_FILTER, 16'sh7FFF);
    send_item(ffc_pkg::CMD_CLEAR, 16'h5A5A);
    send_item(ffc_pkg::CMD_CLEAR, 16'hFFFF);
    send_item(ffc_pkg::CMD_FILTER, 16'sh8000);
    send_item(ffc_pkg::CMD_FILTER, 16'sh8000);
    send_item(ffc_pkg::CMD_FILTER, 16'sh0000);
    send_item(ffc_pkg::CMD_FILTER, 16'sh0080);
    send_item(ffc_pkg::CMD_FILTER, 16'shFF80);
  endtask

  task automatic test_coefficient_extremes();
    logic [COEF_W-1:0] gain [SECTIONS];
    logic [COEF_W-1:0] fbk  [SECTIONS];
    settle();
    // Most negative gain on high-pass sections, where b1 becomes exactly +1.0.
    gain = '{COEF_MIN, COEF_MIN, COEF_MIN};
    fbk  = '{COEF_MAX, COEF_MIN, 18'sd0};
    load_settings(gain, fbk, 18'd0);
    send_item(ffc_pkg::CMD_FILTER, 16'sh8000);
    send_item(ffc_pkg::CMD_FILTER, 16'sh7FFF);
    send_item(ffc_pkg::CMD_FILTER, 16'sh0001);
    random_items(120);
    settle();
    gain = '{COEF_MAX, COEF_MAX, COEF_MAX};
    fbk  = '{COEF_MIN, COEF_MAX, COEF_MIN};
    load_settings(gain, fbk, 18'd7);
    random_items(120);
    settle();
    gain = '{18'sd0, COEF_MAX, 18'sd1};
    fbk  = '{18'sd0, 18'sd0, COEF_MAX};
    load_settings(gain, fbk, 18'd5);
    random_items(60);
  endtask

  task automatic test_register_decode();
    settle();
    // Unused index and bits above the kinds field must both leave the filter unchanged.
    write_reg(REG_SPARE, 18'($urandom));
    write_reg(REG_SPARE, 18'h3FFFF);
    write_reg(REG_KINDS, 18'h3FFF8 | 18'd2);
    @(negedge clk);
    cfg_we = 1'b0;
    random_items(60);
  endtask

  task automatic test_random_settings();
    logic [COEF_W-1:0] gain [SECTIONS];
    logic [COEF_W-1:0] fbk  [SECTIONS];
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      for (int s = 0; s < SECTIONS; s++) begin
        gain[s] = 18'($urandom);
        fbk[s]  = 18'($urandom);
      end
      load_settings(gain, fbk, 18'($urandom));
      steady = (phase == 1);
      random_items(110);
      steady = 1'b0;
    end
  endtask

  task automatic test_restored_defaults();
    logic [COEF_W-1:0] gain [SECTIONS];
    logic [COEF_W-1:0] fbk  [SECTIONS];
    settle();
    for (int s = 0; s < SECTIONS; s++) begin
      gain[s] = 18'(ffc_pkg::GAIN_RESET[s]);
      fbk[s]  = 18'(ffc_pkg::FBK_RESET[s]);
    end
    load_settings(gain, fbk, 18'(ffc_pkg::KINDS_RESET));
    random_items(100);
    steady = 1'b1;
    random_items(60);
    steady = 1'b0;
    random_items(40);
  endtask

  // Result side: ready toggles with random stalls of varied length.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      int stall;
      stall = pick_gap();
      @(negedge clk);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got sample_out %0d clipped %0b",
                 $time, $signed(out_tdata[SMP_BITS-1:0]), out_tuser);
        mismatches++;
      end else begin
        filtered_t want;
        want = pending_results.pop_front();
        if (out_tdata[SMP_BITS-1:0] !== want.smp) begin
          $display("%0t: sample_out expected %0d, got %0d", $time, want.smp,
                   $signed(out_tdata[SMP_BITS-1:0]));
          mismatches++;
        end
        if (out_tuser !== want.clip) begin
          $display("%0t: clipped expected %0b, got %0b", $time, want.clip, out_tuser);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = ffc_pkg::CMD_FILTER;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_data   = '0;
    mismatches = 0;
    steady     = 1'b0;
    for (int s = 0; s < SECTIONS; s++) begin
      sec_gain[s]     = 18'(ffc_pkg::GAIN_RESET[s]);
      sec_fbk[s]      = 18'(ffc_pkg::FBK_RESET[s]);
      sec_prev_in[s]  = '0;
      sec_prev_out[s] = '0;
    end
    sec_lowpass = 3'(ffc_pkg::KINDS_RESET);
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_coefficient_extremes();
    test_register_decode();
    test_random_settings();
    test_restored_defaults();
    settle();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ffc_pkg.sv
src/ffc_cell.sv
src/ffc_out.sv
src/first_order_filter_cascade_unit.sv
test/first_order_filter_cascade_unit_tb.sv
